// ----- rtl/rla_pkg.sv -----
// ----------------------------------------------------------------------------
// rla_pkg
// shared types, codes and helpers for the radio lease arbiter
// ----------------------------------------------------------------------------
package rla_pkg;

   localparam int MODE_W   = 3;
   localparam int OWNER_W  = 2;
   localparam int TIME_W   = 32;
   localparam int HOLD_W   = 16;
   localparam int WINDOW_W = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // request modes
   localparam logic [MODE_W-1:0] MODE_ACQUIRE   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_WEB       = 3'd2;
   localparam logic [MODE_W-1:0] MODE_BLE_CHECK = 3'd3;
   localparam logic [MODE_W-1:0] MODE_QUERY     = 3'd4;

   // radio users
   localparam logic [OWNER_W-1:0] OWNER_NONE   = 2'd0;
   localparam logic [OWNER_W-1:0] OWNER_BLE    = 2'd1;
   localparam logic [OWNER_W-1:0] OWNER_ZIGBEE = 2'd2;
   localparam logic [OWNER_W-1:0] OWNER_MATTER = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WEB_HOLD     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLE_INTERVAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLE_DURATION = 2'd2;

   // register reset values
   localparam logic [HOLD_W-1:0]   WEB_HOLD_RESET     = 16'd1500;
   localparam logic [WINDOW_W-1:0] BLE_INTERVAL_RESET = 20'd30000;
   localparam logic [WINDOW_W-1:0] BLE_DURATION_RESET = 20'd10000;

   typedef struct packed {
      logic [OWNER_W-1:0] owner;
      logic [TIME_W-1:0]  deadline;
      logic [TIME_W-1:0]  web_until;
      logic [TIME_W-1:0]  ble_start;
   } rla_state_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [OWNER_W-1:0] requester;
      logic               lease_zero;
      logic [TIME_W-1:0]  lease_end;
      logic [TIME_W-1:0]  web_end;
      logic [TIME_W-1:0]  now;
   } rla_item_type;

   typedef struct packed {
      logic               granted;
      logic [OWNER_W-1:0] current_owner;
      logic               web_priority_on;
      logic               ble_permit;
      logic               zigbee_allowed;
   } rla_result_type;

   // a strictly before b, wrap-safe
   function automatic logic is_before(input logic [TIME_W-1:0] a,
                                      input logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] d;
      d = b - a;
      return (d != '0) && !d[TIME_W-1];
   endfunction

endpackage

// ----- rtl/rla_step.sv -----
// ----------------------------------------------------------------------------
// rla_step
// one request step: lease expiry, mode action, web hold and ble decision
// ----------------------------------------------------------------------------
module rla_step (
   input  rla_pkg::rla_item_type                 item,
   input  rla_pkg::rla_state_type                state_cur,
   input  logic [rla_pkg::WINDOW_W-1:0]          ble_interval,
   input  logic [rla_pkg::WINDOW_W-1:0]          ble_duration,
   output rla_pkg::rla_state_type                state_nxt,
   output rla_pkg::rla_result_type               result
);
   import rla_pkg::*;

   logic               expired;
   logic [OWNER_W-1:0] owner_live;
   logic [TIME_W-1:0]  deadline_live;
   logic               web_on;
   logic [TIME_W-1:0]  elapsed;
   logic               window_due;

   assign expired = (state_cur.owner != OWNER_NONE) && (state_cur.deadline != '0)
                    && !is_before(item.now, state_cur.deadline);
   assign owner_live    = expired ? OWNER_NONE : state_cur.owner;
   assign deadline_live = expired ? '0 : state_cur.deadline;

   always_comb begin
      state_nxt          = state_cur;
      state_nxt.owner    = owner_live;
      state_nxt.deadline = deadline_live;
      result.granted     = 1'b1;
      case (item.mode)
         MODE_ACQUIRE: begin
            if (owner_live != OWNER_NONE && owner_live != item.requester) begin
               result.granted = 1'b0;
            end else begin
               state_nxt.owner    = item.requester;
               state_nxt.deadline = item.lease_zero ? '0 : item.lease_end;
            end
         end
         MODE_RELEASE: begin
            if (owner_live == item.requester) begin
               state_nxt.owner    = OWNER_NONE;
               state_nxt.deadline = '0;
            end
         end
         MODE_WEB: begin
            // only ever extend the hold
            if (!is_before(item.web_end, state_cur.web_until)) begin
               state_nxt.web_until = item.web_end;
            end
         end
         default: begin
         end
      endcase

      web_on     = is_before(item.now, state_nxt.web_until);
      elapsed    = item.now - state_cur.ble_start;
      window_due = elapsed >= {{(TIME_W-WINDOW_W){1'b0}}, ble_interval};

      if (state_nxt.owner == OWNER_ZIGBEE || state_nxt.owner == OWNER_MATTER) begin
         result.ble_permit = 1'b0;
      end else if (!web_on) begin
         result.ble_permit = 1'b1;
      end else if (window_due) begin
         result.ble_permit = 1'b1;
         if (item.mode == MODE_BLE_CHECK) begin
            state_nxt.ble_start = item.now;
         end
      end else begin
         result.ble_permit = elapsed < {{(TIME_W-WINDOW_W){1'b0}}, ble_duration};
      end

      result.current_owner   = state_nxt.owner;
      result.web_priority_on = web_on;
      result.zigbee_allowed  = !(state_nxt.owner == OWNER_BLE ||
                                 state_nxt.owner == OWNER_MATTER);
   end

endmodule

// ----- rtl/radio_lease_arbiter.sv -----
// ----------------------------------------------------------------------------
// radio_lease_arbiter
// leases one shared radio to one user at a time, with web priority hold and
// periodic ble windows
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake            payload
//   req_      in          req_valid/req_stall  mode, requester, lease_ms, now_ms
//   rsp_      out         rsp_valid/rsp_stall  granted, current_owner,
//                                              web_priority_on, ble_permit,
//                                              zigbee_allowed
//   csr_      in          csr_write_enable     csr_index, csr_write_data
//
// one request per cycle while req_stall is low; a request passes through the input
// register, then the step logic into the result register, which drives rsp_valid
// the lease and web-hold end times are summed while the request is registered
// reset (synchronous) clears owner, deadline, web hold, ble window start and
// the registers to their defaults
// rsp_stall holds the result register and, once the input register is also
// full, raises req_stall in the same cycle
//
module radio_lease_arbiter (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rla_pkg::MODE_W-1:0]    req_mode,
   input  logic [rla_pkg::OWNER_W-1:0]   req_requester,
   input  logic [rla_pkg::TIME_W-1:0]    req_lease_ms,
   input  logic [rla_pkg::TIME_W-1:0]    req_now_ms,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_granted,
   output logic [rla_pkg::OWNER_W-1:0]   rsp_current_owner,
   output logic                          rsp_web_priority_on,
   output logic                          rsp_ble_permit,
   output logic                          rsp_zigbee_allowed,
   // configuration
   input  logic                          csr_write_enable,
   input  logic [rla_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rla_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import rla_pkg::*;

   // configuration registers
   logic [HOLD_W-1:0]   web_hold_ff;
   logic [WINDOW_W-1:0] ble_interval_ff;
   logic [WINDOW_W-1:0] ble_duration_ff;

   // input register
   logic          in_valid_ff;
   rla_item_type  item_ff;
   rla_item_type  item_in;

   // arbiter state
   rla_state_type state_ff;
   rla_state_type state_in;

   // result register
   logic           out_valid_ff;
   rla_result_type result_ff;
   rla_result_type result_in;

   logic advance;
   logic req_take;

   // step fires when the input register is full and the result register is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // end times summed at the input so the step logic sees them ready
   always_comb begin
      item_in.mode       = req_mode;
      item_in.requester  = req_requester;
      item_in.lease_zero = (req_lease_ms == '0);
      item_in.lease_end  = req_now_ms + req_lease_ms;
      item_in.web_end    = req_now_ms + {{(TIME_W-HOLD_W){1'b0}}, web_hold_ff};
      item_in.now        = req_now_ms;
   end

   rla_step u_step (
      .item         (item_ff),
      .state_cur    (state_ff),
      .ble_interval (ble_interval_ff),
      .ble_duration (ble_duration_ff),
      .state_nxt    (state_in),
      .result       (result_in)
   );

   // configuration writes, index beyond the list ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         web_hold_ff     <= WEB_HOLD_RESET;
         ble_interval_ff <= BLE_INTERVAL_RESET;
         ble_duration_ff <= BLE_DURATION_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WEB_HOLD:     web_hold_ff     <= csr_write_data[HOLD_W-1:0];
            CSR_BLE_INTERVAL: ble_interval_ff <= csr_write_data[WINDOW_W-1:0];
            CSR_BLE_DURATION: ble_duration_ff <= csr_write_data[WINDOW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
   end

   // arbiter state moves only when a step fires
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.owner     <= OWNER_NONE;
         state_ff.deadline  <= '0;
         state_ff.web_until <= '0;
         state_ff.ble_start <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_granted         = result_ff.granted;
   assign rsp_current_owner   = result_ff.current_owner;
   assign rsp_web_priority_on = result_ff.web_priority_on;
   assign rsp_ble_permit      = result_ff.ble_permit;
   assign rsp_zigbee_allowed  = result_ff.zigbee_allowed;

endmodule
